[src/record_sort_by_key_with_total_top_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef RECORD_SORT_BY_KEY_WITH_TOTAL_TOP_ASSERT_SVH
`define RECORD_SORT_BY_KEY_WITH_TOTAL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSBT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsbt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsbt assertion failed");

`endif

[src/rsbt_pkg.sv]
`default_nettype none
package rsbt_pkg;

	localparam int CODE_W  = 16;
	localparam int PRICE_W = 24;
	localparam int QTY_W   = 16;
	localparam int PROD_W  = PRICE_W + QTY_W;
	localparam int TOTAL_W = 46;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} rec_t;

	// Per-cycle command broadcast to every cell of the sorting row.
	typedef struct packed {
		logic ins;
		logic drn;
	} cell_ctl_t;

endpackage
`default_nettype wire

[src/record_sort_by_key_with_total_top.sv]
// Loading takes one item per cycle: start is taken in every cycle while busy is low.
// After the item marked last, busy stays high through the wait state and the drain.
// The first result follows the wait state, the drain state and the output register,
// then one result a cycle; results cannot stall.
// Reset clears the row's valid bits, the total, the drop flag and the state.
`default_nettype none
module record_sort_by_key_with_total_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] product_code,
	input  wire logic [23:0] unit_price,
	input  wire logic [15:0] quantity,
	input  wire logic        last_item,
	output logic             result_valid,
	output logic [15:0]      out_code,
	output logic [23:0]      out_price,
	output logic [15:0]      out_quantity,
	output logic             last_result,
	output logic [45:0]      total_amount,
	output logic             dropped
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_WAIT  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                   state_q;
	logic                         accept;
	logic                         full;
	logic                         ovf_q;
	logic                         drain_end;
	rsbt_pkg::cell_ctl_t          ctl;
	rsbt_pkg::rec_t               new_rec;
	rsbt_pkg::rec_t               rec     [CAPACITY];
	logic [CAPACITY-1:0]          vld;
	logic [CAPACITY-1:0]          aft;
	logic [rsbt_pkg::TOTAL_W-1:0] total;

	rsbt_pkg::rec_t               out_rec_q;
	logic                         out_vld_q;
	logic                         out_last_q;
	logic [rsbt_pkg::TOTAL_W-1:0] out_total_q;
	logic                         out_drop_q;

	assign busy      = (state_q != ST_LOAD);
	assign accept    = start && !busy;
	assign full      = vld[CAPACITY-1];
	assign drain_end = (state_q == ST_DRAIN) && !vld[1];

	assign new_rec.code  = product_code;
	assign new_rec.price = unit_price;
	assign new_rec.qty   = quantity;

	assign ctl.ins = accept && !full;
	assign ctl.drn = (state_q == ST_DRAIN);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rsbt_pkg::rec_t lft_rec;
		logic           lft_vld;
		logic           lft_aft;
		rsbt_pkg::rec_t rgt_rec;
		logic           rgt_vld;

		if (i == 0) begin : g_head
			assign lft_rec = '0;
			assign lft_vld = 1'b0;
			assign lft_aft = 1'b0;
		end else begin : g_body
			assign lft_rec = rec[i-1];
			assign lft_vld = vld[i-1];
			assign lft_aft = aft[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rgt_rec = '0;
			assign rgt_vld = 1'b0;
		end else begin : g_inner
			assign rgt_rec = rec[i+1];
			assign rgt_vld = vld[i+1];
		end

		rsbt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.new_rec (new_rec),
			.lft_rec (lft_rec),
			.lft_vld (lft_vld),
			.lft_aft (lft_aft),
			.rgt_rec (rgt_rec),
			.rgt_vld (rgt_vld),
			.rec     (rec[i]),
			.vld     (vld[i]),
			.aft     (aft[i])
		);
	end

	rsbt_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.add    (ctl.ins),
		.clr    (drain_end),
		.price  (unit_price),
		.qty    (quantity),
		.total  (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			ovf_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= ctl.drn;
			if (accept && full) begin
				ovf_q <= 1'b1;
			end else if (drain_end) begin
				ovf_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept && last_item) begin
						state_q <= ST_WAIT;
					end
				end
				// The wait state lets the last product reach the total.
				ST_WAIT: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (drain_end) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drn) begin
			out_rec_q   <= rec[0];
			out_last_q  <= !vld[1];
			out_total_q <= total;
			out_drop_q  <= ovf_q;
		end
	end

	assign result_valid = out_vld_q;
	assign out_code     = out_rec_q.code;
	assign out_price    = out_rec_q.price;
	assign out_quantity = out_rec_q.qty;
	assign last_result  = out_last_q;
	assign total_amount = out_total_q;
	assign dropped      = out_drop_q;

endmodule
`default_nettype wire

[src/rsbt_cell.sv]
`default_nettype none
module rsbt_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rsbt_pkg::cell_ctl_t ctl,
	input  wire rsbt_pkg::rec_t    new_rec,
	input  wire rsbt_pkg::rec_t    lft_rec,
	input  wire logic              lft_vld,
	input  wire logic              lft_aft,
	input  wire rsbt_pkg::rec_t    rgt_rec,
	input  wire logic              rgt_vld,
	output rsbt_pkg::rec_t         rec,
	output logic                   vld,
	output logic                   aft
);

	rsbt_pkg::rec_t rec_q;
	logic           vld_q;

	// A cell lies behind the insertion point when it is empty or holds a
	// strictly greater price, so equal prices keep their arrival order.
	assign aft = !vld_q || (rec_q.price > new_rec.price);
	assign rec = rec_q;
	assign vld = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.drn) begin
			vld_q <= rgt_vld;
		end else if (ctl.ins && aft) begin
			vld_q <= lft_aft ? lft_vld : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drn) begin
			rec_q <= rgt_rec;
		end else if (ctl.ins && aft) begin
			rec_q <= lft_aft ? lft_rec : new_rec;
		end
	end

endmodule
`default_nettype wire

[src/rsbt_accum.sv]
`default_nettype none
module rsbt_accum (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         add,
	input  wire logic                         clr,
	input  wire logic [rsbt_pkg::PRICE_W-1:0] price,
	input  wire logic [rsbt_pkg::QTY_W-1:0]   qty,
	output logic      [rsbt_pkg::TOTAL_W-1:0] total
);

	logic [rsbt_pkg::PROD_W-1:0]  prod_s1;
	logic                         prod_vld_s1;
	logic [rsbt_pkg::TOTAL_W-1:0] total_q;
	logic [rsbt_pkg::TOTAL_W:0]   sum;

	assign sum = {1'b0, total_q}
		+ {{(rsbt_pkg::TOTAL_W + 1 - rsbt_pkg::PROD_W){1'b0}}, prod_s1};
	assign total = total_q;

	always_ff @(posedge clk) begin
		prod_s1 <= rsbt_pkg::PROD_W'(price) * rsbt_pkg::PROD_W'(qty);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			total_q     <= '0;
		end else begin
			prod_vld_s1 <= add;
			if (clr) begin
				total_q <= '0;
			end else if (prod_vld_s1) begin
				// The total saturates instead of wrapping.
				total_q <= sum[rsbt_pkg::TOTAL_W] ? {rsbt_pkg::TOTAL_W{1'b1}}
					: sum[rsbt_pkg::TOTAL_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

[src/rsbt_checker.sv]
`default_nettype none
`include "record_sort_by_key_with_total_top_assert.svh"
module rsbt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic last_item,
	input wire logic result_valid,
	input wire logic last_result
);

	`RSBT_ASSERT_NEXT(a_last_goes_busy, clk, arst_n, start && !busy && last_item, busy)
	`RSBT_ASSERT_SAME(a_run_while_busy, clk, arst_n, result_valid && !last_result, busy)
	`RSBT_ASSERT_NEXT(a_run_unbroken, clk, arst_n, result_valid && !last_result, result_valid)
	`RSBT_ASSERT_NEXT(a_run_ends, clk, arst_n, result_valid && last_result, !result_valid)

endmodule

bind record_sort_by_key_with_total_top rsbt_checker u_rsbt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_item    (last_item),
	.result_valid (result_valid),
	.last_result  (last_result)
);
`default_nettype wire

[tb/sv/record_sort_by_key_with_total_top_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module record_sort_by_key_with_total_top_tb;

	localparam int CAPACITY = 64;
	localparam int RANDOM_ITEMS = 180;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [rsbt_pkg::TOTAL_W-1:0] TOTAL_MAX = {rsbt_pkg::TOTAL_W{1'b1}};

	typedef struct packed {
		rsbt_pkg::rec_t               rec;
		logic                         last;
		logic [rsbt_pkg::TOTAL_W-1:0] total;
		logic                         dropped;
	} sorted_out_t;

	// Keeps the records of the open set in price order and queues the sorted run
	// once the set is closed.
	class sorted_run_board;
		rsbt_pkg::rec_t               held[$];
		logic [rsbt_pkg::TOTAL_W-1:0] total;
		logic                         overflow;
		sorted_out_t                  awaited[$];
		int                           errors;

		function new();
			total = '0;
			overflow = 1'b0;
			errors = 0;
		endfunction

		function void note_item(rsbt_pkg::rec_t r, logic last);
			int pos;
			logic [63:0] sum;
			sorted_out_t o;
			if (held.size() < CAPACITY) begin
				// Insert after every record of equal or lower price, which keeps
				// equal prices in arrival order.
				pos = held.size();
				for (int i = 0; i < held.size(); i++) begin
					if (held[i].price > r.price) begin
						pos = i;
						break;
					end
				end
				held.insert(pos, r);
				sum = 64'(total) + 64'(r.price) * 64'(r.qty);
				total = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[rsbt_pkg::TOTAL_W-1:0];
			end else begin
				overflow = 1'b1;
			end
			if (last) begin
				for (int i = 0; i < held.size(); i++) begin
					o.rec = held[i];
					o.last = (i == held.size() - 1);
					o.total = total;
					o.dropped = overflow;
					awaited.push_back(o);
				end
				held.delete();
				total = '0;
				overflow = 1'b0;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		task check_result(sorted_out_t got);
			sorted_out_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result with none expected, code %h price %h",
					got.rec.code, got.rec.price));
				return;
			end
			want = awaited.pop_front();
			if (got.rec.code !== want.rec.code)
				report($sformatf("out_code %h, expected %h", got.rec.code, want.rec.code));
			if (got.rec.price !== want.rec.price)
				report($sformatf("out_price %h, expected %h", got.rec.price, want.rec.price));
			if (got.rec.qty !== want.rec.qty)
				report($sformatf("out_quantity %h, expected %h", got.rec.qty, want.rec.qty));
			if (got.last !== want.last)
				report($sformatf("last_result %b, expected %b", got.last, want.last));
			if (got.total !== want.total)
				report($sformatf("total_amount %h, expected %h", got.total, want.total));
			if (got.dropped !== want.dropped)
				report($sformatf("dropped %b, expected %b", got.dropped, want.dropped));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] product_code = '0;
	logic [23:0] unit_price = '0;
	logic [15:0] quantity = '0;
	logic        last_item = 1'b0;
	logic        result_valid;
	logic [15:0] out_code;
	logic [23:0] out_price;
	logic [15:0] out_quantity;
	logic        last_result;
	logic [45:0] total_amount;
	logic        dropped;

	sorted_run_board sb = new();
	int cycle_count = 0;
	bit no_gaps = 1'b0;

	record_sort_by_key_with_total_top #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.product_code(product_code),
		.unit_price(unit_price),
		.quantity(quantity),
		.last_item(last_item),
		.result_valid(result_valid),
		.out_code(out_code),
		.out_price(out_price),
		.out_quantity(out_quantity),
		.last_result(last_result),
		.total_amount(total_amount),
		.dropped(dropped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("record_sort_by_key_with_total_top test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result({out_code, out_price, out_quantity, last_result,
				total_amount, dropped});
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Called at a rising edge; returns at the edge where the item was taken,
	// or after the idle gap that follows it.
	task automatic put_item(input logic [15:0] code, input logic [23:0] price,
			input logic [15:0] qty, input logic last);
		rsbt_pkg::rec_t r;
		int gap;
		start <= 1'b1;
		product_code <= code;
		unit_price <= price;
		quantity <= qty;
		last_item <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r.code = code;
		r.price = price;
		r.qty = qty;
		sb.note_item(r, last);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_random_set(input int count);
		logic [23:0] price;
		logic [15:0] qty;
		bit narrow;
		narrow = ($urandom_range(0, 9) < 4);
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			// A narrow price range makes equal keys common, which exercises stability.
			price = narrow ? 24'($urandom_range(0, 7)) : 24'($urandom_range(0, 24'hFFFFFF));
			case ($urandom_range(0, 9))
				0: qty = 16'h0000;
				1: qty = 16'hFFFF;
				default: qty = 16'($urandom_range(0, 16'hFFFF));
			endcase
			put_item(16'($urandom_range(0, 16'hFFFF)), price, qty, i == count - 1);
		end
	endtask

	initial begin
		int sent;
		int set_no;
		int count;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A set of one record, with a zero code and quantity.
		put_item(16'h0000, 24'h000001, 16'h0000, 1'b1);
		// Extremes, a zero price and a run of equal prices.
		put_item(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0);
		put_item(16'h1234, 24'h000000, 16'h0005, 1'b0);
		put_item(16'h0001, 24'h00000A, 16'hFFFF, 1'b0);
		put_item(16'h0002, 24'h00000A, 16'h0001, 1'b0);
		put_item(16'h0003, 24'h00000A, 16'h0002, 1'b0);
		put_item(16'h0004, 24'h000001, 16'h0000, 1'b0);
		put_item(16'h0005, 24'hFFFFFF, 16'h0001, 1'b1);
		// Arrival in falling price order.
		put_item(16'h0A05, 24'd50, 16'd1, 1'b0);
		put_item(16'h0A04, 24'd40, 16'd2, 1'b0);
		put_item(16'h0A03, 24'd30, 16'd3, 1'b0);
		put_item(16'h0A02, 24'd20, 16'd4, 1'b0);
		put_item(16'h0A01, 24'd10, 16'd5, 1'b1);
		// Two records with the largest price and quantity.
		put_item(16'hAAAA, 24'hFFFFFF, 16'hFFFF, 1'b0);
		put_item(16'h5555, 24'hFFFFFF, 16'hFFFF, 1'b1);

		sent = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			if (set_no == 1)
				count = CAPACITY + 3;	// records past the store are dropped
			else if (set_no == 4)
				count = CAPACITY;
			else if ($urandom_range(0, 9) == 0)
				count = $urandom_range(9, CAPACITY);
			else
				count = $urandom_range(1, 8);
			put_random_set(count);
			sent += (count > CAPACITY) ? CAPACITY : count;
			set_no++;
		end
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (CAPACITY + 10) @(posedge clk);
		if (sb.errors == 0)
			$display("record_sort_by_key_with_total_top test passed");
		else
			$display("record_sort_by_key_with_total_top test failed");
		$finish;
	end

endmodule
`default_nettype wire

[record_sort_by_key_with_total_top.f]
+incdir+src
src/rsbt_pkg.sv
src/rsbt_cell.sv
src/rsbt_accum.sv
src/record_sort_by_key_with_total_top.sv
src/rsbt_checker.sv
tb/sv/record_sort_by_key_with_total_top_tb.sv
